@@ sv/dles_pkg.sv @@
// Package: types, codes and constants shared by the DAQ list event scheduler.
package dles_pkg;

  localparam int DEF_MAX_LISTS = 4;
  localparam int DEF_MAX_ODTS  = 16;
  localparam int RES_CAP       = 64;
  localparam int K_W           = $clog2(RES_CAP + 1);
  localparam logic [7:0] PID_LIMIT = 8'hFC;
  localparam int MODE_STIM_BIT   = 1;
  localparam int MODE_STAMP_BIT  = 4;
  localparam int MODE_PIDOFF_BIT = 5;

  typedef enum logic [2:0] {
    FN_FREE        = 3'd0,
    FN_ALLOC_LISTS = 3'd1,
    FN_ALLOC_ODT   = 3'd2,
    FN_SET_MODE    = 3'd3,
    FN_START_STOP  = 3'd4,
    FN_SYNCH       = 3'd5,
    FN_TICK        = 3'd6,
    FN_RSVD        = 3'd7
  } func_t;

  localparam logic [7:0] SS_STOP   = 8'd0;
  localparam logic [7:0] SS_START  = 8'd1;
  localparam logic [7:0] SS_SELECT = 8'd2;
  localparam logic [7:0] SY_STOP_ALL   = 8'd0;
  localparam logic [7:0] SY_START_SEL  = 8'd1;
  localparam logic [7:0] SY_STOP_SEL   = 8'd2;
  localparam logic [7:0] SY_PREP_START = 8'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  list_num;
    logic [7:0]  count;
    logic [7:0]  mode;
    logic [15:0] evt_chan;
    logic [7:0]  prescaler;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        dto_valid;
    logic [1:0]  list_index;
    logic [3:0]  odt_index;
    logic [7:0]  pid;
    logic        pid_present;
    logic        timestamp_present;
    logic [31:0] stamp;
    logic [15:0] dto_count;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_RENUM, ST_SCAN, ST_EMIT, ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic exec_cmd;
    logic renum_step;
    logic scan_step;
    logic emit_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic renum_needed;
    logic renum_last;
    logic scan_in_range;
    logic scan_emit;
    logic emit_last;
    logic slot_free;
    logic out_free;
  } dp_sts_t;

endpackage

@@ sv/daq_list_event_scheduler_top.sv @@
// DAQ list event scheduler: one item at a time. A command item is executed
// and, when ODTs are allocated, followed by PID renumbering (which walks the
// lists one per cycle); it gives one result. A tick item scans the lists,
// visiting one list a cycle, and the emitter produces one descriptor a cycle
// while the output slot is free; output stalls hold up both kinds of item. The
// final result of each item has last set. A new item is taken once the
// previous one's final result is in the output register.
module daq_list_event_scheduler_top #(
  parameter int MAX_LISTS = dles_pkg::DEF_MAX_LISTS,
  parameter int MAX_ODTS  = dles_pkg::DEF_MAX_ODTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dles_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dles_pkg::out_item_t out_data
);
  import dles_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dles_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dles_dp #(
    .MAX_LISTS (MAX_LISTS),
    .MAX_ODTS  (MAX_ODTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ sv/dles_ctrl.sv @@
// Controller: sequences command execution, PID renumbering and tick scans.
module dles_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dles_pkg::dp_sts_t sts,
  output dles_pkg::dp_cmd_t cmd
);
  import dles_pkg::*;

  state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_tick) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.exec_cmd = 1'b1;
          state_nxt    = sts.renum_needed ? ST_RENUM : ST_FINISH;
        end
      end
      ST_RENUM: begin
        cmd.renum_step = 1'b1;
        if (sts.renum_last) state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        if (!sts.scan_in_range) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_emit) state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) state_nxt = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ sv/dles_dp.sv @@
// Datapath: list table, counters, pending result and output register.
module dles_dp #(
  parameter int MAX_LISTS = dles_pkg::DEF_MAX_LISTS,
  parameter int MAX_ODTS  = dles_pkg::DEF_MAX_ODTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dles_pkg::in_item_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output dles_pkg::out_item_t out_data,
  input  dles_pkg::dp_cmd_t   cmd,
  output dles_pkg::dp_sts_t   sts
);
  import dles_pkg::*;

  localparam int LIU_W = $clog2(MAX_LISTS + 1);
  localparam int LI_W  = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int ODT_W = $clog2(MAX_ODTS + 1);

  logic [LIU_W-1:0] liu_r;
  logic             run_r  [MAX_LISTS];
  logic             sel_r  [MAX_LISTS];
  logic [ODT_W-1:0] odts_r [MAX_LISTS];
  logic [7:0]       fpid_r [MAX_LISTS];
  logic [7:0]       mode_r [MAX_LISTS];
  logic [15:0]      chan_r [MAX_LISTS];
  logic [7:0]       div_r  [MAX_LISTS];
  logic [7:0]       dcnt_r [MAX_LISTS];
  logic [15:0]      ctr_r;
  logic [LIU_W-1:0] i_r;
  logic [ODT_W-1:0] j_r;
  logic [K_W-1:0]   k_r;
  logic [7:0]       acc_r;
  in_item_t         item_r;
  out_item_t        pend_r;
  logic             pend_v_r;
  out_item_t        out_r;
  logic             out_v_r;

  logic [LI_W-1:0]  ln_idx, i_idx;
  logic             list_ok, cmd_ok, match, fire;
  logic [7:0]       dcnt_inc;
  logic [8:0]       renum_sum;
  logic [15:0]      ctr_inc;
  out_item_t        desc;
  out_item_t        cmd_res;
  out_item_t        fin_res;

  assign ln_idx  = item_r.list_num[LI_W-1:0];
  assign i_idx   = i_r[LI_W-1:0];
  assign list_ok = (item_r.list_num < 8'(liu_r));

  // accept check per command
  always_comb begin
    unique case (item_r.func)
      FN_FREE:        cmd_ok = 1'b1;
      FN_ALLOC_LISTS: cmd_ok = (item_r.count != 8'd0) && (item_r.count <= 8'(MAX_LISTS));
      FN_ALLOC_ODT:   cmd_ok = list_ok && (item_r.count != 8'd0) &&
                               (item_r.count <= 8'(MAX_ODTS));
      FN_SET_MODE:    cmd_ok = list_ok;
      FN_START_STOP:  cmd_ok = list_ok && (item_r.mode <= SS_SELECT);
      FN_SYNCH:       cmd_ok = (item_r.mode <= SY_PREP_START);
      default:        cmd_ok = 1'b0;
    endcase
  end

  // tick scan of list i
  assign match    = run_r[i_idx] && !mode_r[i_idx][MODE_STIM_BIT] &&
                    (chan_r[i_idx] == item_r.evt_chan);
  assign dcnt_inc = dcnt_r[i_idx] + 8'd1;
  assign fire     = match && (dcnt_inc >= div_r[i_idx]);
  assign renum_sum = {1'b0, acc_r} + 9'(odts_r[i_idx]);
  assign ctr_inc  = ctr_r + 16'd1;

  // descriptor for ODT j of list i
  always_comb begin
    desc                   = '0;
    desc.dto_valid         = 1'b1;
    desc.list_index        = 2'(i_r);
    desc.odt_index         = 4'(j_r);
    desc.pid               = fpid_r[i_idx] + 8'(j_r);
    desc.pid_present       = !mode_r[i_idx][MODE_PIDOFF_BIT];
    desc.timestamp_present = mode_r[i_idx][MODE_STAMP_BIT];
    desc.stamp             = item_r.timestamp;
    desc.dto_count         = ctr_inc;
  end

  // command result and final result of an item
  always_comb begin
    cmd_res        = '0;
    cmd_res.status = !cmd_ok;
    if (cmd_ok && item_r.func == FN_START_STOP) cmd_res.pid = fpid_r[ln_idx];
    fin_res        = pend_v_r ? pend_r : '0;
    fin_res.last   = 1'b1;
  end

  assign sts.is_tick       = (item_r.func == FN_TICK);
  assign sts.renum_needed  = cmd_ok && (item_r.func == FN_ALLOC_ODT);
  assign sts.renum_last    = (i_r == liu_r - LIU_W'(1));
  assign sts.scan_in_range = (i_r < liu_r);
  assign sts.scan_emit     = fire && (odts_r[i_idx] != '0) && (k_r < K_W'(RES_CAP));
  assign sts.emit_last     = (j_r == odts_r[i_idx] - ODT_W'(1)) ||
                             (k_r == K_W'(RES_CAP - 1));
  assign sts.out_free      = !out_v_r || !out_stall;
  assign sts.slot_free     = !pend_v_r || sts.out_free;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      liu_r    <= '0;
      ctr_r    <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      acc_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int n = 0; n < MAX_LISTS; n++) begin
        run_r[n]  <= 1'b0;
        sel_r[n]  <= 1'b0;
        odts_r[n] <= '0;
        fpid_r[n] <= '0;
        mode_r[n] <= '0;
        chan_r[n] <= '0;
        div_r[n]  <= 8'd1;
        dcnt_r[n] <= '0;
      end
    end else begin
      // load the output register, or drop the output item once taken
      if (cmd.finish || (cmd.emit_step && pend_v_r)) out_v_r <= 1'b1;
      else if (out_v_r && !out_stall) out_v_r <= 1'b0;

      // capture the input item
      if (cmd.load_item) begin
        item_r   <= in_data;
        i_r      <= '0;
        k_r      <= '0;
        pend_v_r <= 1'b0;
      end

      // execute a command
      if (cmd.exec_cmd) begin
        pend_r   <= cmd_res;
        pend_v_r <= 1'b1;
        i_r      <= '0;
        acc_r    <= '0;
        if (cmd_ok) begin
          case (item_r.func)
            FN_FREE, FN_ALLOC_LISTS: begin
              liu_r <= (item_r.func == FN_FREE) ? '0 : LIU_W'(item_r.count);
              if (item_r.func == FN_FREE) ctr_r <= '0;
              for (int n = 0; n < MAX_LISTS; n++) begin
                run_r[n]  <= 1'b0;
                sel_r[n]  <= 1'b0;
                odts_r[n] <= '0;
                fpid_r[n] <= '0;
                mode_r[n] <= '0;
                chan_r[n] <= '0;
                div_r[n]  <= 8'd1;
                dcnt_r[n] <= '0;
              end
            end
            FN_ALLOC_ODT: odts_r[ln_idx] <= ODT_W'(item_r.count);
            FN_SET_MODE: begin
              mode_r[ln_idx] <= item_r.mode;
              chan_r[ln_idx] <= item_r.evt_chan;
              div_r[ln_idx]  <= (item_r.prescaler == 8'd0) ? 8'd1 : item_r.prescaler;
              dcnt_r[ln_idx] <= '0;
            end
            FN_START_STOP: begin
              if (item_r.mode == SS_STOP) begin
                run_r[ln_idx] <= 1'b0;
                sel_r[ln_idx] <= 1'b0;
              end else if (item_r.mode == SS_START) begin
                run_r[ln_idx]  <= 1'b1;
                sel_r[ln_idx]  <= 1'b0;
                dcnt_r[ln_idx] <= '0;
              end else begin
                sel_r[ln_idx] <= 1'b1;
              end
            end
            FN_SYNCH: begin
              for (int n = 0; n < MAX_LISTS; n++) begin
                if (LIU_W'(n) < liu_r) begin
                  if (item_r.mode == SY_STOP_ALL) begin
                    run_r[n] <= 1'b0;
                    sel_r[n] <= 1'b0;
                  end else if (item_r.mode == SY_START_SEL && sel_r[n]) begin
                    run_r[n]  <= 1'b1;
                    sel_r[n]  <= 1'b0;
                    dcnt_r[n] <= '0;
                  end else if (item_r.mode == SY_STOP_SEL && sel_r[n]) begin
                    run_r[n] <= 1'b0;
                    sel_r[n] <= 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      // renumber first PIDs, one list a cycle
      if (cmd.renum_step) begin
        fpid_r[i_idx] <= acc_r;
        if (renum_sum <= {1'b0, PID_LIMIT}) acc_r <= renum_sum[7:0];
        i_r <= i_r + LIU_W'(1);
      end

      // advance the prescaler of list i, then start its ODTs or move to the next list
      if (cmd.scan_step) begin
        if (fire) dcnt_r[i_idx] <= '0;
        else if (match) dcnt_r[i_idx] <= dcnt_inc;
        if (sts.scan_emit) j_r <= '0;
        else i_r <= i_r + LIU_W'(1);
      end

      // emit one descriptor, pushing the previous one out
      if (cmd.emit_step) begin
        if (pend_v_r) out_r <= pend_r;
        pend_r   <= desc;
        pend_v_r <= 1'b1;
        ctr_r    <= ctr_inc;
        j_r      <= j_r + ODT_W'(1);
        k_r      <= k_r + K_W'(1);
        if (sts.emit_last) i_r <= i_r + LIU_W'(1);
      end

      // deliver the final item of this input
      if (cmd.finish) begin
        out_r    <= fin_res;
        pend_v_r <= 1'b0;
      end
    end
  end

endmodule

@@ sv/dles_chk.sv @@
// Checker: port-level properties of the scheduler, bound to the top level.
module dles_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dles_pkg::out_item_t out_data
);
  import dles_pkg::*;

  // hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // a rejected command is a single final non-DTO result
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && !out_data.dto_valid)
    else $error("rejected result malformed");

  // a result without DTO is always final
  a_nodto_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dto_valid |-> out_data.last)
    else $error("non-DTO result not final");

endmodule

bind daq_list_event_scheduler_top dles_chk u_chk (.*);
